### rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the three-level FIFO cache lookup.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int TagInW  = 32;
  localparam int LatW    = 16;
  localparam int CntW    = 32;
  localparam int LvlW    = 2;
  localparam int CfgIdxW = 8;

  // Serving level codes.
  localparam logic [LvlW-1:0] LVL_L1  = 2'd0;
  localparam logic [LvlW-1:0] LVL_L2  = 2'd1;
  localparam logic [LvlW-1:0] LVL_L3  = 2'd2;
  localparam logic [LvlW-1:0] LVL_MEM = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_L1_LAT  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_L2_LAT  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_L3_LAT  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEM_LAT = 8'd3;

  // Latency register reset values.
  localparam logic [LatW-1:0] L1_LAT_RST  = 16'd4;
  localparam logic [LatW-1:0] L2_LAT_RST  = 16'd12;
  localparam logic [LatW-1:0] L3_LAT_RST  = 16'd40;
  localparam logic [LatW-1:0] MEM_LAT_RST = 16'd200;

  typedef struct packed {
    logic            accept;    // capture the incoming tag
    logic            scan_clr;  // restart the scan at entry zero
    logic            scan_run;  // read and compare one entry
    logic            finish;    // install, count and load the result
    logic [LvlW-1:0] level;     // level being scanned, or serving level
  } tfc_cmd_t;

  typedef struct packed {
    logic hit;       // registered entry matches the tag
    logic miss_end;  // level holds no more entries to compare
    logic out_full;  // result register cannot take a new beat
  } tfc_status_t;

endpackage

### rtl/tfc_req_if.sv
// ----------------------------------------------------------------------------
// tfc_req_if
// Request channel carrying one block tag per beat.
// ----------------------------------------------------------------------------
interface tfc_req_if import tfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TagInW-1:0] block_tag;

  modport source (output valid, output block_tag, input ready);
  modport sink   (input valid, input block_tag, output ready);
endinterface

### rtl/tfc_rsp_if.sv
// ----------------------------------------------------------------------------
// tfc_rsp_if
// Response channel carrying the serving level, its latency and fetch count.
// ----------------------------------------------------------------------------
interface tfc_rsp_if import tfc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LvlW-1:0] hit_level;
  logic [LatW-1:0] access_latency;
  logic [CntW-1:0] memory_fetch_count;

  modport source (output valid, output hit_level, output access_latency,
                  output memory_fetch_count, input ready);
  modport sink   (input valid, input hit_level, input access_latency,
                  input memory_fetch_count, output ready);
endinterface

### rtl/tfc_cfg_if.sv
// ----------------------------------------------------------------------------
// tfc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tfc_cfg_if import tfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [LatW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/three_level_fifo_cache_lookup.sv
// Operation: the tag is taken first, then each searched level is scanned one
// stored entry at a time until a hit or its last entry (an empty level issues
// no read), and the result register is then loaded.
// Throughput: one request at a time; the rate is set by the single registered
// read port of each level's tag memory, one entry compared per cycle.
// Reset empties all levels by clearing their fill counts, zeroes the fetch
// counter and restores the default latencies; no clearing pass is needed.
// ----------------------------------------------------------------------------
// three_level_fifo_cache_lookup
// Three-level fully associative FIFO cache lookup with memory fetch count.
// ----------------------------------------------------------------------------
module three_level_fifo_cache_lookup import tfc_pkg::*; #(
  parameter int L1_DEPTH  = 32,
  parameter int L2_DEPTH  = 128,
  parameter int L3_DEPTH  = 512,
  parameter int TAG_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfc_req_if.sink   req_i,
  tfc_rsp_if.source rsp_o,
  tfc_cfg_if.sink   cfg_i
);

  tfc_cmd_t    cmd;
  tfc_status_t status;
  logic        req_ready;

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  tfc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tfc_datapath #(
    .L1_DEPTH  (L1_DEPTH),
    .L2_DEPTH  (L2_DEPTH),
    .L3_DEPTH  (L3_DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .block_tag_i          (req_i.block_tag),
    .cfg_valid_i          (cfg_i.valid),
    .cfg_index_i          (cfg_i.index),
    .cfg_data_i           (cfg_i.data),
    .rsp_valid_o          (rsp_o.valid),
    .rsp_ready_i          (rsp_o.ready),
    .hit_level_o          (rsp_o.hit_level),
    .access_latency_o     (rsp_o.access_latency),
    .memory_fetch_count_o (rsp_o.memory_fetch_count)
  );

endmodule

### rtl/tfc_level.sv
// ----------------------------------------------------------------------------
// tfc_level
// One fully associative level: tag memory, fill count and FIFO victim pointer.
// ----------------------------------------------------------------------------
module tfc_level import tfc_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int TAG_W = 32,
  parameter int IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  logic             wr_en_i,
  input  logic [TAG_W-1:0] wr_tag_i,
  output logic [TAG_W-1:0] rd_tag_o,
  output logic             more_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FillW = $clog2(DEPTH + 1);

  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rd_tag_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic [AddrW-1:0] victim_q, victim_d;
  logic [AddrW-1:0] wr_addr;
  logic             full;

  assign full   = (fill_q == FillW'(DEPTH));
  assign more_o = (rd_idx_i < IDX_W'(fill_q));

  // Until the level is full, new tags go to the next free slot.
  always_comb begin
    fill_d   = fill_q;
    victim_d = victim_q;
    wr_addr  = full ? victim_q : fill_q[AddrW-1:0];
    if (wr_en_i) begin
      if (!full) begin
        fill_d = fill_q + FillW'(1);
      end else if (victim_q == AddrW'(DEPTH - 1)) begin
        victim_d = '0;
      end else begin
        victim_d = victim_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      victim_q <= '0;
    end else begin
      fill_q   <= fill_d;
      victim_q <= victim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_tag_q <= mem[rd_idx_i[AddrW-1:0]];
    end
  end

  assign rd_tag_o = rd_tag_q;

endmodule

### rtl/tfc_datapath.sv
// ----------------------------------------------------------------------------
// tfc_datapath
// Tag capture, scan pointer, three tag levels, latency registers and result.
// ----------------------------------------------------------------------------
module tfc_datapath import tfc_pkg::*; #(
  parameter int L1_DEPTH  = 32,
  parameter int L2_DEPTH  = 128,
  parameter int L3_DEPTH  = 512,
  parameter int TAG_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfc_cmd_t           cmd_i,
  output tfc_status_t        status_o,
  input  logic [TagInW-1:0]  block_tag_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LatW-1:0]    cfg_data_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [LvlW-1:0]    hit_level_o,
  output logic [LatW-1:0]    access_latency_o,
  output logic [CntW-1:0]    memory_fetch_count_o
);

  localparam int StoreW   = (TAG_WIDTH < TagInW) ? TAG_WIDTH : TagInW;
  localparam int MaxDepth12 = (L1_DEPTH > L2_DEPTH) ? L1_DEPTH : L2_DEPTH;
  localparam int MaxDepth = (MaxDepth12 > L3_DEPTH) ? MaxDepth12 : L3_DEPTH;
  localparam int IdxW     = $clog2(MaxDepth + 1);

  logic [StoreW-1:0] tag_q;
  logic [IdxW-1:0]   idx_q;
  logic              pend_q;
  logic [StoreW-1:0] rd_tag_l1, rd_tag_l2, rd_tag_l3;
  logic [StoreW-1:0] sel_tag;
  logic [2:0]        more, rd_en, wr_en;
  logic              sel_more;
  logic [LatW-1:0]   lat_q [4];
  logic [CntW-1:0]   fetch_cnt_q, fetch_cnt_d;
  logic              rsp_valid_q;
  logic [LvlW-1:0]   out_level_q;
  logic [LatW-1:0]   out_lat_q;
  logic [CntW-1:0]   out_cnt_q;

  // Only the level under scan reads; every level with a lower code than the server is filled.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_en[k] = cmd_i.scan_run && !cmd_i.scan_clr && more[k] &&
                 (cmd_i.level == LvlW'(k));
      wr_en[k] = cmd_i.finish && (LvlW'(k) < cmd_i.level);
    end
  end

  tfc_level #(.DEPTH(L1_DEPTH), .TAG_W(StoreW), .IDX_W(IdxW)) u_l1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en[0]),
    .rd_idx_i (idx_q),
    .wr_en_i  (wr_en[0]),
    .wr_tag_i (tag_q),
    .rd_tag_o (rd_tag_l1),
    .more_o   (more[0])
  );

  tfc_level #(.DEPTH(L2_DEPTH), .TAG_W(StoreW), .IDX_W(IdxW)) u_l2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en[1]),
    .rd_idx_i (idx_q),
    .wr_en_i  (wr_en[1]),
    .wr_tag_i (tag_q),
    .rd_tag_o (rd_tag_l2),
    .more_o   (more[1])
  );

  tfc_level #(.DEPTH(L3_DEPTH), .TAG_W(StoreW), .IDX_W(IdxW)) u_l3 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en[2]),
    .rd_idx_i (idx_q),
    .wr_en_i  (wr_en[2]),
    .wr_tag_i (tag_q),
    .rd_tag_o (rd_tag_l3),
    .more_o   (more[2])
  );

  always_comb begin
    case (cmd_i.level)
      LVL_L2: begin
        sel_tag  = rd_tag_l2;
        sel_more = more[1];
      end
      LVL_L3: begin
        sel_tag  = rd_tag_l3;
        sel_more = more[2];
      end
      default: begin
        sel_tag  = rd_tag_l1;
        sel_more = more[0];
      end
    endcase
  end

  // The read issued last cycle is compared now, so a level is done only
  // when no read is in flight and no entry is left.
  assign status_o.hit      = pend_q && (sel_tag == tag_q);
  assign status_o.miss_end = !pend_q && !sel_more;
  assign status_o.out_full = rsp_valid_q && !rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.accept || cmd_i.scan_clr) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      pend_q <= sel_more;
      if (sel_more) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tag_q <= block_tag_i[StoreW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q[0] <= L1_LAT_RST;
      lat_q[1] <= L2_LAT_RST;
      lat_q[2] <= L3_LAT_RST;
      lat_q[3] <= MEM_LAT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_L1_LAT:  lat_q[0] <= cfg_data_i;
        CFG_L2_LAT:  lat_q[1] <= cfg_data_i;
        CFG_L3_LAT:  lat_q[2] <= cfg_data_i;
        CFG_MEM_LAT: lat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fetch_cnt_d = (cmd_i.level == LVL_MEM) ? fetch_cnt_q + CntW'(1) : fetch_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_cnt_q <= '0;
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      fetch_cnt_q <= fetch_cnt_d;
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_level_q <= cmd_i.level;
      out_lat_q   <= lat_q[cmd_i.level];
      out_cnt_q   <= fetch_cnt_d;
    end
  end

  assign rsp_valid_o          = rsp_valid_q;
  assign hit_level_o          = out_level_q;
  assign access_latency_o     = out_lat_q;
  assign memory_fetch_count_o = out_cnt_q;

endmodule

### rtl/tfc_controller.sv
// ----------------------------------------------------------------------------
// tfc_controller
// Sequences the level scans of one request and hands the result over.
// ----------------------------------------------------------------------------
module tfc_controller import tfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  tfc_status_t status_i,
  output tfc_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [LvlW-1:0] lvl_q, lvl_d;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.level = lvl_q;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          lvl_d        = LVL_L1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.hit) begin
          state_d = S_DONE;
        end else if (status_i.miss_end) begin
          // Past the last level the request goes to main memory.
          lvl_d          = lvl_q + LvlW'(1);
          cmd_o.scan_clr = 1'b1;
          if (lvl_q == LVL_L3) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!status_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= LVL_L1;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

endmodule
